/* hdl/keyed_quoted_value_extractor_defines.svh */
// assertion macros for the keyed quoted value extractor
// needs clk and rst_n in the scope where a macro is used
`ifndef KEYED_QUOTED_VALUE_EXTRACTOR_DEFINES_SVH
`define KEYED_QUOTED_VALUE_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define KQVE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kqve check failed");

// next-cycle implication
`define KQVE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kqve check failed");

`endif

/* hdl/kqve_pkg.sv */
// shared types, constants and character class functions
// for the keyed quoted value extractor; no dependencies
`default_nettype none

package kqve_pkg;

    localparam int MAX_VALUE_DEF = 64;
    localparam int KEY_LEN = 4;

    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_KEY,
        PH_EQ,
        PH_QUOTE,
        PH_VALUE,
        PH_DONE
    } kqve_phase_t;

    typedef enum logic [1:0] {
        ST_CHAR  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NONE  = 2'd2
    } kqve_status_t;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } kqve_text_t;

    typedef struct packed {
        logic [7:0]   value_char;
        kqve_status_t status;
        logic         truncated;
        logic         last;
    } kqve_result_t;

    // parser to readout
    typedef struct packed {
        logic         go_read;
        logic         emit;
        kqve_status_t status;
    } kqve_evt_t;

    // readout to parser
    typedef struct packed {
        logic busy;
        logic hold;
    } kqve_stat_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
               (c == CH_UNDERSCORE);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h6E;
            3'd1:    r = 8'h61;
            3'd2:    r = 8'h6D;
            3'd3:    r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/kqve_value_ram.sv */
// value buffer: one write port, one registered read port
// depends on nothing but its parameters
`default_nettype none

module kqve_value_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] value_mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= value_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/kqve_parser.sv */
// text parser: key word search, '=' and quote matching, value buffering
// uses kqve_pkg; writes the value ram and hands events to the readout
`default_nettype none

module kqve_parser #(
    parameter int MAX_VALUE = kqve_pkg::MAX_VALUE_DEF,
    parameter int AW        = 6,
    parameter int LW        = 7
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                text_valid,
    output logic                     text_stall,
    input  wire kqve_pkg::kqve_text_t text,
    input  wire kqve_pkg::kqve_stat_t stat,
    output kqve_pkg::kqve_evt_t      evt,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [7:0]               wr_data,
    output logic [LW-1:0]            value_length,
    output logic                     overflowed
);

    import kqve_pkg::*;

    kqve_phase_t   phase_reg, phase_next, phase_mid;
    logic [2:0]    key_reg, key_next, key_mid;
    logic          prev_reg, prev_next;
    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic          accept;
    logic [7:0]    lc;
    logic          room;

    assign text_stall = stat.busy | stat.hold;
    assign accept     = text_valid & ~text_stall;
    assign lc         = to_lower(text.ch);
    assign room       = len_reg < LW'(MAX_VALUE);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        key_next   = key_reg;
        prev_next  = prev_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        phase_mid  = phase_reg;
        key_mid    = key_reg;
        if (accept)
        begin
            if (text.action)
            begin
                phase_next = PH_SEEK;
                key_next   = 3'd0;
                prev_next  = 1'b0;
                len_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_KEY:
                    begin
                        if (key_reg < 3'(KEY_LEN) && lc == key_char(key_reg))
                        begin
                            key_mid = key_reg + 3'd1;
                            if (key_mid == 3'(KEY_LEN))
                            begin
                                phase_mid = PH_EQ;
                            end
                        end
                        else
                        begin
                            phase_mid = PH_SEEK;
                            key_mid   = 3'd0;
                        end
                    end
                    PH_EQ:
                    begin
                        if (text.ch == CH_EQUAL)
                        begin
                            phase_mid = PH_QUOTE;
                        end
                        else if (!is_blank(text.ch))
                        begin
                            phase_mid = PH_SEEK;
                        end
                    end
                    PH_QUOTE:
                    begin
                        if (text.ch == CH_QUOTE)
                        begin
                            phase_mid = PH_VALUE;
                            len_next  = '0;
                            ovf_next  = 1'b0;
                        end
                        else if (!is_blank(text.ch))
                        begin
                            phase_mid = PH_SEEK;
                        end
                    end
                    PH_VALUE:
                    begin
                        if (text.ch == CH_QUOTE)
                        begin
                            phase_mid = PH_DONE;
                        end
                        else if (room)
                        begin
                            len_next = len_reg + LW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    PH_SEEK, PH_DONE:
                    begin
                    end
                    default:
                    begin
                        phase_mid = PH_SEEK;
                    end
                endcase
                // a byte that broke an attempt may start the key word
                if (phase_mid == PH_SEEK)
                begin
                    key_mid = 3'd0;
                    if (!prev_reg && lc == key_char(3'd0))
                    begin
                        phase_mid = PH_KEY;
                        key_mid   = 3'd1;
                    end
                end
                phase_next = phase_mid;
                key_next   = key_mid;
                prev_next  = is_word(text.ch);
            end
        end
    end

    // outputs
    always_comb
    begin
        evt.go_read = 1'b0;
        evt.emit    = 1'b0;
        evt.status  = ST_CHAR;
        wr_en       = 1'b0;
        wr_addr     = len_reg[AW-1:0];
        wr_data     = text.ch;
        if (accept)
        begin
            if (text.action)
            begin
                if (phase_reg != PH_DONE)
                begin
                    evt.emit   = 1'b1;
                    evt.status = ST_NONE;
                end
            end
            else if (phase_reg == PH_VALUE)
            begin
                if (text.ch == CH_QUOTE)
                begin
                    if (len_reg == '0)
                    begin
                        evt.emit   = 1'b1;
                        evt.status = ST_EMPTY;
                    end
                    else
                    begin
                        evt.go_read = 1'b1;
                    end
                end
                else if (room)
                begin
                    wr_en = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            key_reg   <= 3'd0;
            prev_reg  <= 1'b0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
            prev_reg  <= prev_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign value_length = len_reg;
    assign overflowed   = ovf_reg;

endmodule

`default_nettype wire

/* hdl/kqve_readout.sv */
// readout sequencer: walks the value ram and owns the result register
// uses kqve_pkg and the assertion macros
`default_nettype none

`include "keyed_quoted_value_extractor_defines.svh"

module kqve_readout #(
    parameter int AW = 6,
    parameter int LW = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire kqve_pkg::kqve_evt_t   evt,
    input  wire logic [LW-1:0]         value_length,
    input  wire logic                  overflowed,
    output kqve_pkg::kqve_stat_t       stat,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  wire logic [7:0]            rd_data,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output kqve_pkg::kqve_result_t     result
);

    import kqve_pkg::*;

    logic          busy_reg, busy_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic          out_valid_reg, out_valid_next;
    kqve_result_t  out_reg, out_next;
    logic          load;
    logic          issue;

    assign load  = pend_reg & (~out_valid_reg | ~result_stall);
    assign issue = busy_reg & (idx_reg != value_length) & (~pend_reg | load);

    assign rd_en   = issue;
    assign rd_addr = idx_reg[AW-1:0];

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (evt.go_read)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end

        if (issue)
        begin
            idx_next       = idx_reg + LW'(1);
            pend_next      = 1'b1;
            pend_last_next = (idx_reg + LW'(1)) == value_length;
        end
        else if (load)
        begin
            pend_next = 1'b0;
        end

        if (load && pend_last_reg)
        begin
            busy_next = 1'b0;
        end

        if (load)
        begin
            out_valid_next       = 1'b1;
            out_next.value_char  = rd_data;
            out_next.status      = ST_CHAR;
            out_next.truncated   = overflowed;
            out_next.last        = pend_last_reg;
        end
        else if (evt.emit)
        begin
            out_valid_next       = 1'b1;
            out_next.value_char  = 8'h00;
            out_next.status      = evt.status;
            out_next.truncated   = 1'b0;
            out_next.last        = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign stat.busy    = busy_reg;
    assign stat.hold    = out_valid_reg & result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `KQVE_ASSERT_NOW(a_idx_in_range, busy_reg, idx_reg <= value_length)
    `KQVE_ASSERT_NOW(a_no_emit_while_busy, evt.emit || evt.go_read, !busy_reg)
    `KQVE_ASSERT_NOW(a_pend_only_busy, pend_reg, busy_reg)
    `KQVE_ASSERT_NEXT(a_start_busy, evt.go_read, busy_reg && idx_reg == '0)

endmodule

`default_nettype wire

/* hdl/keyed_quoted_value_extractor.sv */
// top level of the keyed quoted value extractor
// uses kqve_pkg, kqve_value_ram, kqve_parser and kqve_readout
//
//   channel   direction   payload          handshake
//   text      in          kqve_text_t      text_valid / text_stall
//   result    out         kqve_result_t    result_valid / result_stall
//
// one text character per cycle while the readout is idle and no result is held up
// a value drains byte by byte through the ram read port,
// text is stalled until the last byte has entered the result register
// rst_n is asynchronous, active low; the value ram needs no clearing pass
// text stalls while the result register is full and result is stalled
`default_nettype none

module keyed_quoted_value_extractor #(
    parameter int MAX_VALUE = kqve_pkg::MAX_VALUE_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   text_valid,
    output logic                        text_stall,
    input  wire kqve_pkg::kqve_text_t   text,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output kqve_pkg::kqve_result_t      result
);

    import kqve_pkg::*;

    localparam int AW = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;
    localparam int LW = $clog2(MAX_VALUE + 1);

    kqve_evt_t     evt;
    kqve_stat_t    stat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [LW-1:0] value_length;
    logic          overflowed;

    kqve_value_ram #(
        .DEPTH (MAX_VALUE),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kqve_parser #(
        .MAX_VALUE (MAX_VALUE),
        .AW        (AW),
        .LW        (LW)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text         (text),
        .stat         (stat),
        .evt          (evt),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .value_length (value_length),
        .overflowed   (overflowed)
    );

    kqve_readout #(
        .AW (AW),
        .LW (LW)
    ) u_readout (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt          (evt),
        .value_length (value_length),
        .overflowed   (overflowed),
        .stat         (stat),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
